FILE: rtl/core/lgge_pkg.sv
package lgge_pkg;

  localparam int CMD_W     = 2;
  localparam int COORD_W   = 6;
  localparam int CNT_W     = 4;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

endpackage

FILE: rtl/core/lgge_ifs.sv
interface lgge_cmd_if;
  import lgge_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic               cell_value;
  modport source (output valid, command, row, col, cell_value, input ready);
  modport sink (input valid, command, row, col, cell_value, output ready);
endinterface

interface lgge_res_if;
  import lgge_pkg::*;
  logic             valid;
  logic             ready;
  logic             cell_alive;
  logic [CNT_W-1:0] neighbour_count;
  logic             out_of_range;
  modport source (output valid, cell_alive, neighbour_count, out_of_range, input ready);
  modport sink (input valid, cell_alive, neighbour_count, out_of_range, output ready);
endinterface

interface lgge_cfg_if;
  import lgge_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/life_grid_generation_engine.sv
// write: fetch the row, WB, OUT; read: fetch the row and both neighbours, COUNT, OUT; unused
// command or bad coordinate: OUT; step: one cell per cycle via the shared neighbor counter
// the grid is a row-wide memory with one read and one write port; a row fetch is ISSUE, CAPT
// one command at a time; the next is taken while the last result waits in the output register
// rst (synchronous) clears control and config, then a clearing pass
// zeroes the grid, one row a cycle, with no command taken meanwhile
module life_grid_generation_engine #(
  parameter int MAX_ROWS = lgge_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = lgge_pkg::DEF_MAX_COLS
) (
  input logic        clk,
  input logic        rst,
  lgge_cmd_if.sink   cmd,
  lgge_res_if.source res,
  lgge_cfg_if.sink   cfg
);
  import lgge_pkg::*;

  localparam int RI  = $clog2(MAX_ROWS);
  localparam int CI  = $clog2(MAX_COLS);
  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int ERW = (RW > CFG_W) ? RW : CFG_W;
  localparam int ECW = (CW > CFG_W) ? CW : CFG_W;
  localparam int RCW = (RW > COORD_W) ? RW : COORD_W;
  localparam int CCW = (CW > COORD_W) ? CW : COORD_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_CAPT  = 3'd3;
  localparam logic [2:0] ST_SWEEP = 3'd4;
  localparam logic [2:0] ST_WB    = 3'd5;
  localparam logic [2:0] ST_COUNT = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  localparam logic [1:0] SLOT_CUR = 2'd0;
  localparam logic [1:0] SLOT_UP  = 2'd1;
  localparam logic [1:0] SLOT_DN  = 2'd2;

  logic [CFG_W-1:0] rows_in_use;
  logic [CFG_W-1:0] cols_in_use;
  logic [RW-1:0]    nr;
  logic [CW-1:0]    nc;
  logic [RI-1:0]    nr_m1;
  logic [CI-1:0]    nc_m1;

  logic [2:0]       state;
  logic [CMD_W-1:0] op;
  logic [RI-1:0]    rrow;
  logic [RI-1:0]    rrow_inc;
  logic [CI-1:0]    ccol;
  logic [CI-1:0]    lat_col;
  logic             lat_val;
  logic [1:0]       fslot;

  logic [MAX_COLS-1:0] up_row, cur_row, dn_row, row0_row, new_row;
  logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
  logic [MAX_COLS-1:0] rd_data;
  logic [MAX_COLS-1:0] wr_row;
  logic [MAX_COLS-1:0] wd;
  logic [RI-1:0]       ra;
  logic                we;

  logic             res_alive;
  logic [CNT_W-1:0] res_count;
  logic             res_oor;

  logic [CI-1:0]    uc, cl, cr;
  logic [CNT_W-1:0] cnt;
  logic             rule_next;
  logic             coord_bad;
  logic             cmd_beat;
  logic             res_load;

  // effective wrap limits: zero acts as one, too large acts as the maximum
  always_comb begin
    logic [ERW-1:0] rv;
    logic [ECW-1:0] cv;
    rv = ERW'(rows_in_use);
    cv = ECW'(cols_in_use);
    if (rv == '0) begin
      nr = RW'(1);
    end else if (rv > ERW'(MAX_ROWS)) begin
      nr = RW'(MAX_ROWS);
    end else begin
      nr = RW'(rv);
    end
    if (cv == '0) begin
      nc = CW'(1);
    end else if (cv > ECW'(MAX_COLS)) begin
      nc = CW'(MAX_COLS);
    end else begin
      nc = CW'(cv);
    end
  end

  assign nr_m1    = RI'(nr - 1'b1);
  assign nc_m1    = CI'(nc - 1'b1);
  assign rrow_inc = rrow + 1'b1;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= CFG_RESET;
      cols_in_use <= CFG_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ROWS: rows_in_use <= cfg.data;
        REG_COLS: cols_in_use <= cfg.data;
        default:  ;
      endcase
    end
  end

  // shared neighbor counter and rule
  assign uc = (state == ST_COUNT) ? lat_col : ccol;
  assign cl = (uc == '0) ? nc_m1 : uc - 1'b1;
  assign cr = (uc == nc_m1) ? '0 : uc + 1'b1;
  assign cnt = CNT_W'(up_row[cl]) + CNT_W'(up_row[uc]) + CNT_W'(up_row[cr])
             + CNT_W'(cur_row[cl]) + CNT_W'(cur_row[cr])
             + CNT_W'(dn_row[cl]) + CNT_W'(dn_row[uc]) + CNT_W'(dn_row[cr]);
  assign rule_next = (cnt == CNT_W'(3)) || (cur_row[uc] && (cnt == CNT_W'(2)));

  assign coord_bad = (RCW'(cmd.row) >= RCW'(nr)) || (CCW'(cmd.col) >= CCW'(nc));

  // row fetch address by slot, with wrap
  always_comb begin
    case (fslot)
      SLOT_UP: ra = (rrow == '0) ? nr_m1 : rrow - 1'b1;
      SLOT_DN: ra = (rrow == nr_m1) ? '0 : rrow_inc;
      default: ra = rrow;
    endcase
  end

  // fetched row with the written cell merged in
  always_comb begin
    wr_row          = rd_data;
    wr_row[lat_col] = lat_val;
  end

  assign we = (state == ST_CLEAR) || (state == ST_WB);
  assign wd = (state == ST_WB) ? new_row : '0;

  always_ff @(posedge clk) begin
    if (we) begin
      grid_mem[rrow] <= wd;
    end
    rd_data <= grid_mem[ra];
  end

  assign cmd.ready = (state == ST_IDLE);
  assign cmd_beat  = cmd.valid && cmd.ready;
  assign res_load  = (state == ST_OUT) && (!res.valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      rrow  <= '0;
      fslot <= SLOT_CUR;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          rrow <= rrow + 1'b1;
          if (rrow == RI'(MAX_ROWS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_beat) begin
            fslot <= SLOT_CUR;
            if (cmd.command == CMD_STEP) begin
              rrow  <= '0;
              state <= ST_ISSUE;
            end else if ((cmd.command == CMD_WRITE || cmd.command == CMD_READ)
                         && !coord_bad) begin
              rrow  <= RI'(cmd.row);
              state <= ST_ISSUE;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_ISSUE: state <= ST_CAPT;
        ST_CAPT: begin
          case (fslot)
            SLOT_CUR: begin
              if (op == CMD_WRITE) begin
                state <= ST_WB;
              end else begin
                fslot <= SLOT_UP;
                state <= ST_ISSUE;
              end
            end
            SLOT_UP: begin
              fslot <= SLOT_DN;
              state <= ST_ISSUE;
            end
            default: state <= (op == CMD_READ) ? ST_COUNT : ST_SWEEP;
          endcase
        end
        ST_SWEEP: begin
          if (ccol == nc_m1) begin
            state <= ST_WB;
          end
        end
        ST_WB: begin
          if (op == CMD_WRITE || rrow == nr_m1) begin
            state <= ST_OUT;
          end else begin
            rrow <= rrow_inc;
            if (rrow_inc == nr_m1) begin
              state <= ST_SWEEP;
            end else begin
              fslot <= SLOT_DN;
              state <= ST_ISSUE;
            end
          end
        end
        ST_COUNT: state <= ST_OUT;
        ST_OUT: begin
          if (res_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // row buffers, sweep column and result fields
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (cmd_beat) begin
          op        <= cmd.command;
          lat_col   <= CI'(cmd.col);
          lat_val   <= cmd.cell_value;
          res_alive <= 1'b0;
          res_count <= '0;
          res_oor   <= (cmd.command == CMD_WRITE || cmd.command == CMD_READ) && coord_bad;
        end
      end
      ST_CAPT: begin
        case (fslot)
          SLOT_CUR: begin
            cur_row  <= rd_data;
            row0_row <= rd_data;
            new_row  <= (op == CMD_WRITE) ? wr_row : rd_data;
          end
          SLOT_UP: up_row <= rd_data;
          default: begin
            dn_row <= rd_data;
            ccol   <= '0;
          end
        endcase
      end
      ST_SWEEP: begin
        new_row[ccol] <= rule_next;
        ccol          <= ccol + 1'b1;
      end
      ST_WB: begin
        // slide the window down one row, the old rows stay unwritten copies
        up_row  <= cur_row;
        cur_row <= dn_row;
        new_row <= dn_row;
        ccol    <= '0;
        if (rrow_inc == nr_m1) begin
          dn_row <= row0_row;
        end
      end
      ST_COUNT: begin
        res_alive <= cur_row[lat_col];
        res_count <= cnt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (res_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.cell_alive      <= res_alive;
      res.neighbour_count <= res_count;
      res.out_of_range    <= res_oor;
    end
  end

endmodule
